/* design/rtt_pkg.sv */
// ----------------------------------------------------------------------------
// rtt_pkg: shared types and constants of the refreshable timeout table
// Command and status codes, the entry record held by each table cell,
// and the control state encoding.
// ----------------------------------------------------------------------------
package rtt_pkg;

    localparam int DEFAULT_TABLE_ENTRIES = 16;
    localparam int DEFAULT_WHEEL_SLOTS   = 60;

    localparam int ID_W     = 32;
    localparam int DELAY_W  = 16;
    localparam int PERIOD_W = 7;

    typedef enum logic [1:0] {
        CMD_ADD     = 2'd0,
        CMD_REFRESH = 2'd1,
        CMD_REMOVE  = 2'd2,
        CMD_TICK    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_NOT_FOUND = 2'd2
    } status_t;

    localparam logic KIND_DONE    = 1'b0;
    localparam logic KIND_EXPIRED = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_DONE
    } state_t;

    typedef struct packed {
        logic                valid;
        logic [ID_W-1:0]     id;
        logic [PERIOD_W-1:0] period;
        logic [PERIOD_W-1:0] countdown;
    } entry_t;

endpackage

/* design/rtt_cell.sv */
// ----------------------------------------------------------------------------
// rtt_cell: one table entry in the rotating chain
// Holds one entry and takes its neighbor's entry whenever the chain advances.
// ----------------------------------------------------------------------------
module rtt_cell (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           shift_en,
    input  rtt_pkg::entry_t d_in,
    output rtt_pkg::entry_t q
);
    import rtt_pkg::*;

    logic                valid_reg;
    logic [ID_W-1:0]     id_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic [PERIOD_W-1:0] countdown_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (shift_en) begin
            valid_reg <= d_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            id_reg        <= d_in.id;
            period_reg    <= d_in.period;
            countdown_reg <= d_in.countdown;
        end
    end

    assign q = '{valid: valid_reg, id: id_reg, period: period_reg,
                 countdown: countdown_reg};

endmodule

/* design/rtt_mod_unit.sv */
// ----------------------------------------------------------------------------
// rtt_mod_unit: reduction of a delay modulo the wheel size
// Reciprocal multiplication, each result registered: quotient first, then the
// remainder; a zero remainder maps to the full wheel size.
// ----------------------------------------------------------------------------
module rtt_mod_unit #(
    parameter int WHEEL_SLOTS = rtt_pkg::DEFAULT_WHEEL_SLOTS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [rtt_pkg::DELAY_W-1:0]  dividend,
    output logic                         done,
    output logic [rtt_pkg::PERIOD_W-1:0] period
);
    import rtt_pkg::*;

    // floor(x / WHEEL_SLOTS) equals (x * RECIP) >> SHIFT for every DELAY_W-bit x
    localparam int SHIFT  = DELAY_W + $clog2(WHEEL_SLOTS);
    localparam int PROD_W = 2 * DELAY_W + 1;
    localparam logic [PROD_W-1:0]   RECIP   =
        PROD_W'(((2 ** SHIFT) + WHEEL_SLOTS - 1) / WHEEL_SLOTS);
    localparam logic [DELAY_W-1:0]  SLOTS_D = DELAY_W'(WHEEL_SLOTS);
    localparam logic [PERIOD_W-1:0] SLOTS   = PERIOD_W'(WHEEL_SLOTS);

    logic                busy_reg;
    logic                quot_ok_reg;
    logic [DELAY_W-1:0]  dividend_reg;
    logic [DELAY_W-1:0]  quot_reg;
    logic [PERIOD_W-1:0] rem_reg;

    logic [PROD_W-1:0]   product;
    logic [DELAY_W-1:0]  back;
    logic [DELAY_W-1:0]  diff;

    assign product = PROD_W'(dividend_reg) * RECIP;
    // quotient times modulus never exceeds the dividend, so DELAY_W bits hold it
    assign back    = quot_reg * SLOTS_D;
    assign diff    = dividend_reg - back;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            quot_ok_reg <= 1'b0;
        end else if (start) begin
            busy_reg    <= 1'b1;
            quot_ok_reg <= 1'b0;
        end else if (busy_reg) begin
            quot_ok_reg <= 1'b1;
            if (quot_ok_reg) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dividend_reg <= dividend;
        end else if (busy_reg) begin
            if (quot_ok_reg) begin
                rem_reg <= diff[PERIOD_W-1:0];
            end else begin
                quot_reg <= DELAY_W'(product >> SHIFT);
            end
        end
    end

    assign done   = !busy_reg;
    assign period = (rem_reg == '0) ? SLOTS : rem_reg;

endmodule

/* design/refreshable_timeout_table_unit.sv */
// ----------------------------------------------------------------------------
// refreshable_timeout_table_unit: timer table keyed by task id
// Top level: rotating chain of entry cells, scan control and result register.
// ----------------------------------------------------------------------------
// The table lives in a ring of TABLE_ENTRIES cells that rotates by one entry
// per cycle unless the scan is held; control looks only at the head cell,
// edits it and feeds it back into the tail, so one full revolution visits
// every entry in ascending order and leaves the ring as it was, with the
// edits applied. A tick, refresh or remove takes one revolution: the accept
// step, TABLE_ENTRIES scan steps and the load of the closing item, held
// while an expiry item or the closing item finds the result register
// occupied and not being taken. An add takes two revolutions (one to find
// the live id or the lowest free entry, one to write it). The delay modulo
// unit runs during the search revolution, so the write revolution never
// waits for it. An add that finds neither its id nor a free entry skips the
// write revolution and reports a full table.
// Expiry items carry event_kind 1 and last 0; every input item closes with
// exactly one item with last 1. A new item is taken as soon as the closing
// item is in the result register, even while that item is still waiting to
// be taken.
// ----------------------------------------------------------------------------
module refreshable_timeout_table_unit #(
    parameter int TABLE_ENTRIES = rtt_pkg::DEFAULT_TABLE_ENTRIES,
    parameter int WHEEL_SLOTS   = rtt_pkg::DEFAULT_WHEEL_SLOTS
) (
    input  logic                        aclk,
    input  logic                        aresetn,

    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_cmd,
    input  logic [rtt_pkg::ID_W-1:0]    s_task_id,
    input  logic [rtt_pkg::DELAY_W-1:0] s_delay_ticks,

    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_event_kind,
    output logic [rtt_pkg::ID_W-1:0]    m_event_id,
    output logic [1:0]                  m_status,
    output logic                        m_last
);
    import rtt_pkg::*;

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

    // Control state
    state_t  state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic    found_reg, found_next;
    logic    free_found_reg, free_found_next;
    logic [IW-1:0] match_idx_reg, match_idx_next;
    logic [IW-1:0] free_idx_reg, free_idx_next;
    status_t status_reg, status_next;

    // Captured input item
    cmd_t               cmd_reg;
    logic [ID_W-1:0]    id_reg;

    // Result register
    logic               m_valid_reg;
    logic               m_kind_reg;
    logic [ID_W-1:0]    m_id_reg;
    logic [1:0]         m_status_reg;
    logic               m_last_reg;

    // Datapath
    entry_t             cell_q [TABLE_ENTRIES];
    entry_t             head;
    entry_t             wb;
    logic               shift_en;
    logic               step_ok;
    logic               match;
    logic               last_step;
    logic [IW-1:0]      target_idx;
    logic               out_free;
    logic               load_out;
    logic               out_kind;
    logic [ID_W-1:0]    out_id;
    logic [1:0]         out_status;
    logic               out_last;
    logic               accept;

    logic                mod_start;
    logic                mod_done;
    logic [PERIOD_W-1:0] mod_period;

    // ------------------------------------------------------------------
    // Ring of entry cells: cell i takes from cell i+1, the tail takes the
    // edited head entry.
    // ------------------------------------------------------------------
    for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
        entry_t d_in;
        if (i == TABLE_ENTRIES - 1) begin : g_tail
            assign d_in = wb;
        end else begin : g_mid
            assign d_in = cell_q[i+1];
        end
        rtt_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift_en (shift_en),
            .d_in     (d_in),
            .q        (cell_q[i])
        );
    end

    assign head = cell_q[0];

    // Delay reduction runs alongside the search revolution of an add
    rtt_mod_unit #(
        .WHEEL_SLOTS (WHEEL_SLOTS)
    ) u_mod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (mod_start),
        .dividend (s_delay_ticks),
        .done     (mod_done),
        .period   (mod_period)
    );

    assign s_ready   = (state_reg == S_IDLE);
    assign accept    = s_valid && s_ready;
    assign mod_start = accept && (cmd_t'(s_cmd) == CMD_ADD);

    assign out_free   = !m_valid_reg || m_ready;
    assign match      = head.valid && (head.id == id_reg);
    assign last_step  = (idx_reg == LAST_IDX);
    assign target_idx = found_reg ? match_idx_reg : free_idx_reg;

    // ------------------------------------------------------------------
    // Next state, head edit and result selection
    // ------------------------------------------------------------------
    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        found_next      = found_reg;
        free_found_next = free_found_reg;
        match_idx_next  = match_idx_reg;
        free_idx_next   = free_idx_reg;
        status_next     = status_reg;
        wb              = head;
        step_ok         = 1'b0;
        shift_en        = 1'b0;
        load_out        = 1'b0;
        out_kind        = KIND_DONE;
        out_id          = id_reg;
        out_status      = STAT_OK;
        out_last        = 1'b1;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next      = S_SCAN;
                    idx_next        = '0;
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                    status_next     = STAT_OK;
                end
            end

            S_SCAN: begin
                step_ok = 1'b1;
                unique case (cmd_reg)
                    CMD_TICK: begin
                        if (head.valid) begin
                            if (head.countdown <= PERIOD_W'(1)) begin
                                // expire: hold the ring until the item fits
                                step_ok      = out_free;
                                load_out     = out_free;
                                out_kind     = KIND_EXPIRED;
                                out_id       = head.id;
                                out_last     = 1'b0;
                                wb.valid     = 1'b0;
                                wb.countdown = '0;
                            end else begin
                                wb.countdown = head.countdown - PERIOD_W'(1);
                            end
                        end
                    end
                    CMD_REFRESH: begin
                        if (match) begin
                            wb.countdown = head.period;
                            found_next   = 1'b1;
                        end
                    end
                    CMD_REMOVE: begin
                        if (match) begin
                            wb.valid   = 1'b0;
                            found_next = 1'b1;
                        end
                    end
                    CMD_ADD: begin
                        if (match) begin
                            found_next     = 1'b1;
                            match_idx_next = idx_reg;
                        end
                        if (!head.valid && !free_found_reg) begin
                            free_found_next = 1'b1;
                            free_idx_next   = idx_reg;
                        end
                    end
                    default: ;
                endcase

                if (step_ok) begin
                    shift_en = 1'b1;
                    idx_next = last_step ? '0 : idx_reg + IW'(1);
                    if (last_step) begin
                        unique case (cmd_reg)
                            CMD_ADD: begin
                                if (found_next || free_found_next) begin
                                    state_next = S_WRITE;
                                end else begin
                                    status_next = STAT_FULL;
                                    state_next  = S_DONE;
                                end
                            end
                            CMD_REFRESH, CMD_REMOVE: begin
                                status_next = found_next ? STAT_OK : STAT_NOT_FOUND;
                                state_next  = S_DONE;
                            end
                            default: begin
                                state_next = S_DONE;
                            end
                        endcase
                    end
                end
            end

            S_WRITE: begin
                // hold the ring until the period is ready
                step_ok = mod_done;
                if (idx_reg == target_idx) begin
                    wb.valid     = 1'b1;
                    wb.id        = id_reg;
                    wb.period    = mod_period;
                    wb.countdown = mod_period;
                end
                if (step_ok) begin
                    shift_en = 1'b1;
                    idx_next = last_step ? '0 : idx_reg + IW'(1);
                    if (last_step) begin
                        state_next = S_DONE;
                    end
                end
            end

            S_DONE: begin
                if (out_free) begin
                    load_out   = 1'b1;
                    out_status = status_reg;
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            status_reg     <= STAT_OK;
        end else begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            found_reg      <= found_next;
            free_found_reg <= free_found_next;
            status_reg     <= status_next;
        end
    end

    always_ff @(posedge aclk) begin
        match_idx_reg <= match_idx_next;
        free_idx_reg  <= free_idx_next;
        if (accept) begin
            cmd_reg <= cmd_t'(s_cmd);
            id_reg  <= s_task_id;
        end
    end

    // Result register parts the scan from the consumer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_kind_reg   <= out_kind;
            m_id_reg     <= out_id;
            m_status_reg <= out_status;
            m_last_reg   <= out_last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_event_kind = m_kind_reg;
    assign m_event_id   = m_id_reg;
    assign m_status     = m_status_reg;
    assign m_last       = m_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_write_waits_for_period: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WRITE && shift_en) |-> mod_done
    ) else $error("add written before its period was ready");

    a_expiry_not_last: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_valid && m_event_kind == KIND_EXPIRED) |-> (!m_last && m_status == STAT_OK)
    ) else $error("expiry item with last or nonzero status");

    a_ring_aligned_when_idle: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> (idx_reg == '0)
    ) else $error("ring not back at entry zero while idle");

    a_no_overwrite: assert property (
        @(posedge aclk) disable iff (!aresetn)
        load_out |-> out_free
    ) else $error("result register loaded while still occupied");

endmodule

/* tb/refreshable_timeout_table_unit_tb.sv */
// ----------------------------------------------------------------------------
// refreshable_timeout_table_unit_tb: self-checking bench for the timer table
// Drives add, refresh, remove and tick commands with random idle bursts on
// both channels. A scoreboard keeps its own copy of the table and checks every
// expiry and closing item against it, in order and field by field.
// ----------------------------------------------------------------------------
module refreshable_timeout_table_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import rtt_pkg::*;

    localparam int NUM_ENTRIES  = DEFAULT_TABLE_ENTRIES;
    localparam int NUM_SLOTS    = DEFAULT_WHEEL_SLOTS;
    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 8;
    localparam int RANDOM_ITEMS = 400;
    localparam int ID_POOL      = 24;
    // Items left in the command queue when idling on both sides stops.
    localparam int TAIL_ITEMS   = 40;
    // An add needs two ring revolutions plus its accept and closing steps;
    // sender gaps and receiver stalls come on top of that.
    // Take the sum many times over for the no-progress limit.
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 64;

    // One command item as it goes on the input channel.
    typedef struct {
        cmd_t                 cmd;
        logic [ID_W-1:0]      id;
        logic [DELAY_W-1:0]   delay;
    } timer_cmd_t;

    // One result item as the table should emit it.
    typedef struct {
        logic                 kind;
        logic [ID_W-1:0]      id;
        status_t              status;
        logic                 last;
    } timer_event_t;

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 s_valid       = 1'b0;
    logic                 s_ready;
    logic [1:0]           s_cmd         = CMD_TICK;
    logic [ID_W-1:0]      s_task_id     = '0;
    logic [DELAY_W-1:0]   s_delay_ticks = '0;
    logic                 m_valid;
    logic                 m_ready       = 1'b0;
    logic                 m_event_kind;
    logic [ID_W-1:0]      m_event_id;
    logic [1:0]           m_status;
    logic                 m_last;

    // Scoreboard copy of the timer table.
    logic                 timer_live   [NUM_ENTRIES];
    logic [ID_W-1:0]      timer_id     [NUM_ENTRIES];
    logic [PERIOD_W-1:0]  timer_period [NUM_ENTRIES];
    logic [PERIOD_W-1:0]  timer_count  [NUM_ENTRIES];

    timer_cmd_t           cmd_queue[$];
    timer_event_t         pending_events[$];
    timer_cmd_t           in_flight;
    timer_event_t         expected_ev;
    logic [ID_W-1:0]      id_pool [ID_POOL];

    int                   fail_count    = 0;
    int                   src_gap       = 0;
    int                   sink_gap      = 0;
    int                   quiet_cycles  = 0;
    int                   cmds_done     = 0;
    int                   results_seen  = 0;
    int                   n_expired     = 0;
    int                   n_full        = 0;
    int                   n_not_found   = 0;
    int                   n_replaced    = 0;

    refreshable_timeout_table_unit #(
        .TABLE_ENTRIES (NUM_ENTRIES),
        .WHEEL_SLOTS   (NUM_SLOTS)
    ) DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_task_id     (s_task_id),
        .s_delay_ticks (s_delay_ticks),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_event_kind  (m_event_kind),
        .m_event_id    (m_event_id),
        .m_status      (m_status),
        .m_last        (m_last)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Scoreboard: apply one accepted command to the table copy and queue the
    // items it must produce: expiries first (tick only), then one closing item.
    // ------------------------------------------------------------------------
    function automatic void apply_command(input timer_cmd_t c);
        int           hit;
        int           free_slot;
        int           modv;
        status_t      st;
        timer_event_t ev;
        st        = STAT_OK;
        hit       = -1;
        free_slot = -1;
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            if (timer_live[i] && timer_id[i] == c.id && hit < 0)
                hit = i;
            if (!timer_live[i] && free_slot < 0)
                free_slot = i;
        end
        case (c.cmd)
            CMD_ADD: begin
                // Zero remainder means a full wheel revolution.
                modv = int'(c.delay) % NUM_SLOTS;
                if (modv == 0)
                    modv = NUM_SLOTS;
                if (hit >= 0)
                    n_replaced++;
                else
                    hit = free_slot;
                if (hit < 0) begin
                    st = STAT_FULL;
                    n_full++;
                end else begin
                    timer_live[hit]   = 1'b1;
                    timer_id[hit]     = c.id;
                    timer_period[hit] = PERIOD_W'(modv);
                    timer_count[hit]  = PERIOD_W'(modv);
                end
            end
            CMD_REFRESH: begin
                if (hit < 0) begin
                    st = STAT_NOT_FOUND;
                    n_not_found++;
                end else begin
                    timer_count[hit] = timer_period[hit];
                end
            end
            CMD_REMOVE: begin
                if (hit < 0) begin
                    st = STAT_NOT_FOUND;
                    n_not_found++;
                end else begin
                    timer_live[hit] = 1'b0;
                end
            end
            default: begin
                // Tick: expire in ascending entry order, free as we go.
                for (int i = 0; i < NUM_ENTRIES; i++) begin
                    if (!timer_live[i])
                        continue;
                    if (timer_count[i] <= 1) begin
                        timer_count[i] = '0;
                        timer_live[i]  = 1'b0;
                        ev.kind   = KIND_EXPIRED;
                        ev.id     = timer_id[i];
                        ev.status = STAT_OK;
                        ev.last   = 1'b0;
                        pending_events.insert(pending_events.size(), ev);
                        n_expired++;
                    end else begin
                        timer_count[i] = timer_count[i] - 1'b1;
                    end
                end
            end
        endcase
        ev.kind   = KIND_DONE;
        ev.id     = c.id;
        ev.status = st;
        ev.last   = 1'b1;
        pending_events.insert(pending_events.size(), ev);
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    task automatic queue_cmd(input cmd_t cmd, input logic [ID_W-1:0] id,
                             input logic [DELAY_W-1:0] delay);
        timer_cmd_t c;
        c.cmd   = cmd;
        c.id    = id;
        c.delay = delay;
        cmd_queue.insert(cmd_queue.size(), c);
    endtask

    // Mostly short periods so that timers actually expire, some wrapped
    // through whole wheel turns, some anywhere in the 16-bit range.
    function automatic logic [DELAY_W-1:0] pick_delay();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return DELAY_W'($urandom_range(1, 6));
        else if (r < 8)
            return DELAY_W'(NUM_SLOTS * $urandom_range(0, 1092) + $urandom_range(0, 6));
        else
            return DELAY_W'($urandom);
    endfunction

    // Mostly ids from a small pool so refresh and remove find live timers.
    function automatic logic [ID_W-1:0] pick_id();
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        return id_pool[$urandom_range(0, ID_POOL - 1)];
    endfunction

    // ------------------------------------------------------------------------
    // Driver: hold the item until accepted, then advance to the next one or
    // idle for a random burst. No idling once the queue runs low.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            src_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                apply_command(in_flight);
                cmds_done++;
            end
            if (!s_valid || s_ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_valid <= 1'b0;
                end else if (cmd_queue.size() > 0) begin
                    in_flight = cmd_queue.pop_front();
                    s_valid       <= 1'b1;
                    s_cmd         <= in_flight.cmd;
                    s_task_id     <= in_flight.id;
                    s_delay_ticks <= in_flight.delay;
                    if (cmd_queue.size() >= TAIL_ITEMS && $urandom_range(0, 3) == 0)
                        src_gap = $urandom_range(1, 8);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check each accepted result against the oldest expectation and
    // drop ready for random bursts until the tail of the run.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            sink_gap = 0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (pending_events.size() == 0) begin
                    $error("unexpected result item: event_kind %0d event_id %h",
                           m_event_kind, m_event_id);
                    fail_count++;
                end else begin
                    expected_ev = pending_events.pop_front();
                    if (m_event_kind !== expected_ev.kind) begin
                        $error("event_kind expected %0d got %0d",
                               expected_ev.kind, m_event_kind);
                        fail_count++;
                    end
                    if (m_event_id !== expected_ev.id) begin
                        $error("event_id expected %h got %h",
                               expected_ev.id, m_event_id);
                        fail_count++;
                    end
                    if (m_status !== expected_ev.status) begin
                        $error("status expected %0d got %0d",
                               expected_ev.status, m_status);
                        fail_count++;
                    end
                    if (m_last !== expected_ev.last) begin
                        $error("last expected %0d got %0d",
                               expected_ev.last, m_last);
                        fail_count++;
                    end
                end
            end
            if (sink_gap > 0) begin
                sink_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (cmd_queue.size() >= TAIL_ITEMS && $urandom_range(0, 5) == 0)
                    sink_gap = $urandom_range(1, 8);
            end
        end
    end

    // Watchdog: end the run if neither channel moves for too long.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("timeout: %0d results still expected", pending_events.size());
                $display("refreshable_timeout_table_unit_tb NOT OK");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence: directed corner cases, then random traffic, then drain.
    // ------------------------------------------------------------------------
    initial begin
        logic [DELAY_W-1:0] fill_delays [NUM_ENTRIES];
        int                 target;
        int                 pick;
        int                 base;

        fill_delays = '{16'd0, 16'd60, 16'hFFFF, 16'd1, 16'd1, 16'd2, 16'd61, 16'd120,
                        16'd3, 16'd59, 16'd5, 16'd4, 16'd7, 16'd600, 16'd2, 16'd30000};

        for (int i = 0; i < NUM_ENTRIES; i++)
            timer_live[i] = 1'b0;

        // The pool starts with the all-zero and all-one ids.
        id_pool[0] = '0;
        id_pool[1] = '1;
        for (int i = 2; i < ID_POOL; i++)
            id_pool[i] = $urandom;

        // Tick on an empty table: done marker only.
        queue_cmd(CMD_TICK, '1, '1);
        // Fill every entry; zero, wheel multiples and the largest delay.
        for (int i = 0; i < NUM_ENTRIES; i++)
            queue_cmd(CMD_ADD, id_pool[i], fill_delays[i]);
        // Table full, then replace a live id in place.
        queue_cmd(CMD_ADD, id_pool[NUM_ENTRIES], 16'd3);
        queue_cmd(CMD_ADD, id_pool[3], 16'd2);
        // Refresh and remove, hit and miss.
        queue_cmd(CMD_REFRESH, id_pool[4], '0);
        queue_cmd(CMD_REFRESH, id_pool[NUM_ENTRIES + 1], '1);
        queue_cmd(CMD_REMOVE, id_pool[5], '0);
        queue_cmd(CMD_REMOVE, id_pool[NUM_ENTRIES + 2], '1);
        // Ticks that expire the short timers.
        queue_cmd(CMD_TICK, '0, '0);
        queue_cmd(CMD_TICK, $urandom, 16'($urandom));

        target = cmd_queue.size() + RANDOM_ITEMS;
        while (cmd_queue.size() < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                // Burst of adds over distinct ids, enough to hit a full table.
                base = $urandom_range(0, ID_POOL - 1);
                for (int k = 0; k <= NUM_ENTRIES; k++)
                    queue_cmd(CMD_ADD, id_pool[(base + k) % ID_POOL], pick_delay());
            end else if (pick < 36) begin
                queue_cmd(CMD_TICK, $urandom, 16'($urandom));
            end else if (pick < 66) begin
                queue_cmd(CMD_ADD, pick_id(), pick_delay());
            end else if (pick < 83) begin
                queue_cmd(CMD_REFRESH, pick_id(), 16'($urandom));
            end else begin
                queue_cmd(CMD_REMOVE, pick_id(), 16'($urandom));
            end
        end

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Wait until every command is in, then until every result is out.
        while (cmd_queue.size() != 0 || s_valid)
            @(posedge aclk);
        while (pending_events.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("ran %0d commands, checked %0d result items", cmds_done, results_seen);
        $display("%0d expiries, %0d table-full, %0d id-not-found, %0d replaced ids",
                 n_expired, n_full, n_not_found, n_replaced);
        if (fail_count == 0) begin
            $display("refreshable_timeout_table_unit_tb OK");
        end else begin
            $display("refreshable_timeout_table_unit_tb NOT OK");
        end
        $finish;
    end

endmodule
